FILE: rtl/sseg4_pkg.sv
package sseg4_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned MagWidth   = 14;

  localparam logic signed [ValueWidth-1:0] ValMax = 16'sd9999;
  localparam logic signed [ValueWidth-1:0] ValMin = -16'sd999;

  localparam logic [SegWidth-1:0] SegBlank = 8'h00;
  localparam logic [SegWidth-1:0] SegMinus = 8'h40;

  typedef struct packed {
    logic       neg;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [SegWidth-1:0] seg_of(input logic [3:0] d);
    logic [SegWidth-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/sseg4_digits.sv
module sseg4_digits (
  input  logic signed [sseg4_pkg::ValueWidth-1:0] value_i,
  output sseg4_pkg::digits_t                      digits_o
);
  import sseg4_pkg::*;

  logic signed [ValueWidth-1:0] clamped;
  logic [ValueWidth-1:0]        abs_val;
  logic [MagWidth-1:0]          mag;
  logic [MagWidth-1:0]          rem_th;
  logic [9:0]                   rem_hu;
  logic [6:0]                   rem_te;
  logic [3:0]                   q_th;
  logic [3:0]                   q_hu;
  logic [3:0]                   q_te;

  always_comb begin
    if (value_i > ValMax) begin
      clamped = ValMax;
    end else if (value_i < ValMin) begin
      clamped = ValMin;
    end else begin
      clamped = value_i;
    end
    abs_val = clamped[ValueWidth-1] ? (~clamped + 16'd1) : clamped;
    mag     = abs_val[MagWidth-1:0];
  end

  // split off one decimal digit per level by parallel compares
  always_comb begin
    q_th   = 4'd0;
    rem_th = mag;
    for (int k = 1; k < 10; k++) begin
      if (mag >= MagWidth'(k * 1000)) begin
        q_th   = 4'(k);
        rem_th = mag - MagWidth'(k * 1000);
      end
    end
  end

  always_comb begin
    q_hu   = 4'd0;
    rem_hu = rem_th[9:0];
    for (int k = 1; k < 10; k++) begin
      if (rem_th[9:0] >= 10'(k * 100)) begin
        q_hu   = 4'(k);
        rem_hu = rem_th[9:0] - 10'(k * 100);
      end
    end
  end

  always_comb begin
    q_te   = 4'd0;
    rem_te = rem_hu[6:0];
    for (int k = 1; k < 10; k++) begin
      if (rem_hu[6:0] >= 7'(k * 10)) begin
        q_te   = 4'(k);
        rem_te = rem_hu[6:0] - 7'(k * 10);
      end
    end
  end

  assign digits_o.neg       = clamped[ValueWidth-1];
  assign digits_o.thousands = q_th;
  assign digits_o.hundreds  = q_hu;
  assign digits_o.tens      = q_te;
  assign digits_o.ones      = rem_te[3:0];

endmodule

FILE: rtl/sseg4_encode.sv
module sseg4_encode (
  input  sseg4_pkg::digits_t              digits_i,
  input  logic                            keep_leading_zeros_i,
  output logic [sseg4_pkg::SegWidth-1:0]  digit_thousands_o,
  output logic [sseg4_pkg::SegWidth-1:0]  digit_hundreds_o,
  output logic [sseg4_pkg::SegWidth-1:0]  digit_tens_o,
  output logic [sseg4_pkg::SegWidth-1:0]  digit_ones_o
);
  import sseg4_pkg::*;

  logic blank_th;
  logic blank_hu;
  logic blank_te;

  // a dash does not end the run of leading zeros
  assign blank_th = !keep_leading_zeros_i && (digits_i.neg || (digits_i.thousands == 4'd0));
  assign blank_hu = blank_th && (digits_i.hundreds == 4'd0);
  assign blank_te = blank_hu && (digits_i.tens == 4'd0);

  assign digit_thousands_o = digits_i.neg ? SegMinus :
                             (blank_th ? SegBlank : seg_of(digits_i.thousands));
  assign digit_hundreds_o  = blank_hu ? SegBlank : seg_of(digits_i.hundreds);
  assign digit_tens_o      = blank_te ? SegBlank : seg_of(digits_i.tens);
  assign digit_ones_o      = seg_of(digits_i.ones);

endmodule

FILE: rtl/signed_int_to_four_digit_segments_core.sv
// Signed integer to four seven-segment digit codes.
//
// Slave channel s_axis: tdata carries the signed 16-bit value, tuser the
// keep-leading-zeros flag. Master channel m_axis: tdata carries four
// gfedcba segment codes, thousands digit in the lowest byte, ones digit in
// the highest byte. A transaction completes when tvalid and tready are high
// at a rising edge of clk_i.
//
// An input transaction is held in the input register, then passes through
// clamp, digit split and encode into the result register, which drives
// m_axis. Throughput is one item per cycle while m_axis does not stall; the
// digit split is three levels of parallel compare and subtract.
//
// When m_axis stalls, the result register holds its item and the input
// register can still take one more item; s_axis_tready then drops until
// m_axis_tready returns. rst_ni (asynchronous, active low) empties both
// registers; no item is in flight after reset.
module signed_int_to_four_digit_segments_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic        s_axis_tuser,   // [0] keep_leading_zeros
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [7:0] digit_thousands, [15:8] digit_hundreds,
                                      // [23:16] digit_tens, [31:24] digit_ones
);
  import sseg4_pkg::*;

  logic                         in_valid_q, in_valid_d;
  logic signed [ValueWidth-1:0] in_value_q;
  logic                         in_keep_q;
  logic                         out_valid_q, out_valid_d;
  logic [31:0]                  out_data_q;

  logic                         out_free;
  logic                         in_take;
  logic                         in_move;
  digits_t                      digits;
  logic [SegWidth-1:0]          seg_th;
  logic [SegWidth-1:0]          seg_hu;
  logic [SegWidth-1:0]          seg_te;
  logic [SegWidth-1:0]          seg_on;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_move       = in_valid_q && out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (in_move) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (in_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_value_q <= s_axis_tdata;
      in_keep_q  <= s_axis_tuser;
    end
    if (in_move) begin
      out_data_q <= {seg_on, seg_te, seg_hu, seg_th};
    end
  end

  sseg4_digits u_digits (
    .value_i  (in_value_q),
    .digits_o (digits)
  );

  sseg4_encode u_encode (
    .digits_i             (digits),
    .keep_leading_zeros_i (in_keep_q),
    .digit_thousands_o    (seg_th),
    .digit_hundreds_o     (seg_hu),
    .digit_tens_o         (seg_te),
    .digit_ones_o         (seg_on)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
